// File: rtl/ggs_pkg.sv
`default_nettype none

package ggs_pkg;

	// Grid geometry and field widths
	localparam int CRD_W       = 6;
	localparam int ADDR_W      = 2 * CRD_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int MAX_COLS    = 64;
	localparam int MAX_ROWS    = 64;
	localparam int MIN_SIZE    = 3;
	localparam int VAL_W       = 32;
	localparam int CLS_W       = 5;
	localparam int CFG_W       = 7;
	localparam int CFG_AW      = 1;

	// Stream payload widths, padded to whole bytes
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 64;

	// Arithmetic widths
	localparam int ACC_W     = 37;
	localparam int MAG_W     = 36;
	localparam int DIV_W     = 36;
	localparam int DIV_STEPS = DIV_W / 4;

	// Read sequence lengths after the center read
	localparam int STEP_W      = 3;
	localparam int TAPS_FLUID  = 8;
	localparam int TAPS_EDGE   = 4;

	// Class codes
	localparam logic [CLS_W-1:0] CLASS_FLUID = 5'd0;
	localparam logic [CLS_W-1:0] CLASS_SOLID = 5'd20;

	// Request kinds
	localparam logic REQ_WRITE = 1'b0;

	// Configuration register indexes
	localparam logic [CFG_AW-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_AW-1:0] CFG_GRID_HEIGHT = 1'b1;

	// Neighbor selector along one axis
	typedef enum logic [2:0] {
		SEL_C,
		SEL_P,
		SEL_N,
		SEL_P2,
		SEL_N2
	} sel_t;

	// Stencil weight applied to one read
	typedef enum logic [2:0] {
		CF_ZERO,
		CF_P1,
		CF_M1,
		CF_P3,
		CF_M3,
		CF_P4,
		CF_M4
	} coef_t;

	// Difference scheme along one axis
	typedef enum logic [1:0] {
		AX_CTR,
		AX_FWD,
		AX_BWD
	} axis_t;

	typedef struct packed {
		logic  solid;
		logic  fluid;
		axis_t xm;
		axis_t ym;
	} mode_t;

	typedef struct packed {
		sel_t  xs;
		sel_t  ys;
		coef_t cx;
		coef_t cy;
	} tap_t;

	typedef struct packed {
		logic capture;
		logic mem_we;
		logic rd_en;
		logic rd_center;
		tap_t tap;
		logic div_start;
		logic out_load;
		logic out_skip;
	} cmd_t;

	typedef struct packed {
		logic  is_wr;
		logic  in_grid;
		mode_t mode;
		logic  div_done;
		logic  out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/ggs_div3.sv
`default_nettype none

module ggs_div3 (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ggs_pkg::DIV_W-1:0] dividend,
	output logic      [ggs_pkg::DIV_W-1:0] quotient,
	output logic                           done
);

	localparam int CNT_W = $clog2(ggs_pkg::DIV_STEPS + 1);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [ggs_pkg::DIV_W-1:0] sh_q;
	logic [1:0]                rem_q;

	logic [5:0]  cur;
	logic [11:0] prod;
	logic [3:0]  qd;
	logic [5:0]  rd;

	// One nibble a step: remainder stays below 3, so cur stays below 48
	always_comb begin
		cur  = {rem_q, sh_q[ggs_pkg::DIV_W-1 -: 4]};
		prod = {6'd0, cur} * 12'd43;
		qd   = prod[10:7];
		rd   = cur - ({2'b00, qd} + {1'b0, qd, 1'b0});
	end

	// Shift quotient digits in as dividend digits go out
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= 2'b00;
		end else if (busy_q) begin
			sh_q  <= {sh_q[ggs_pkg::DIV_W-5:0], qd};
			rem_q <= rd[1:0];
		end
	end

	// Step count and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(ggs_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign quotient = sh_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// File: rtl/ggs_dp.sv
`default_nettype none

module ggs_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ggs_pkg::cmd_t               cmd,
	output ggs_pkg::sts_t                    sts,
	input  wire logic                        in_type,
	input  wire logic [ggs_pkg::CRD_W-1:0]   in_x,
	input  wire logic [ggs_pkg::CRD_W-1:0]   in_y,
	input  wire logic [ggs_pkg::VAL_W-1:0]   in_value,
	input  wire logic [ggs_pkg::CLS_W-1:0]   in_class,
	input  wire logic                        cfg_we,
	input  wire logic [ggs_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic [ggs_pkg::CFG_W-1:0]   cfg_wdata,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic      [ggs_pkg::VAL_W-1:0]   deriv_x,
	output logic      [ggs_pkg::VAL_W-1:0]   deriv_y,
	output logic                             skipped
);

	localparam int WORD_W = ggs_pkg::VAL_W + ggs_pkg::CLS_W;

	// Clamp a size register into the usable range
	function automatic logic [ggs_pkg::CFG_W-1:0] clamp_size(
		input logic [ggs_pkg::CFG_W-1:0] r,
		input logic [ggs_pkg::CFG_W-1:0] hi
	);
		logic [ggs_pkg::CFG_W-1:0] s;
		if (r < ggs_pkg::CFG_W'(ggs_pkg::MIN_SIZE)) s = ggs_pkg::CFG_W'(ggs_pkg::MIN_SIZE);
		else if (r > hi) s = hi;
		else s = r;
		return s;
	endfunction

	// Neighbor index along one axis, mirrored back inside [0, n)
	function automatic logic [ggs_pkg::CRD_W-1:0] nbr(
		input ggs_pkg::sel_t             s,
		input logic [ggs_pkg::CRD_W-1:0] c,
		input logic [ggs_pkg::CFG_W-1:0] n
	);
		logic [ggs_pkg::CFG_W-1:0] c7;
		logic [ggs_pkg::CFG_W-1:0] nm1;
		logic [ggs_pkg::CFG_W-1:0] r;
		c7  = ggs_pkg::CFG_W'(c);
		nm1 = n - ggs_pkg::CFG_W'(1);
		case (s)
			ggs_pkg::SEL_P: begin
				r = (c7 == nm1) ? c7 - ggs_pkg::CFG_W'(1) : c7 + ggs_pkg::CFG_W'(1);
			end
			ggs_pkg::SEL_N: begin
				r = (c7 == '0) ? c7 + ggs_pkg::CFG_W'(1) : c7 - ggs_pkg::CFG_W'(1);
			end
			ggs_pkg::SEL_P2: begin
				if (c7 + ggs_pkg::CFG_W'(2) == n) r = c7;
				else if (c7 == nm1) r = c7 - ggs_pkg::CFG_W'(2);
				else r = c7 + ggs_pkg::CFG_W'(2);
			end
			ggs_pkg::SEL_N2: begin
				if (c7 == ggs_pkg::CFG_W'(1)) r = c7;
				else if (c7 == '0) r = ggs_pkg::CFG_W'(2);
				else r = c7 - ggs_pkg::CFG_W'(2);
			end
			default: r = c7;
		endcase
		return r[ggs_pkg::CRD_W-1:0];
	endfunction

	// Decode a class code into the per-axis scheme
	function automatic ggs_pkg::mode_t class_mode(input logic [ggs_pkg::CLS_W-1:0] cls);
		ggs_pkg::mode_t m;
		m.solid = (cls == ggs_pkg::CLASS_SOLID);
		m.fluid = (cls == ggs_pkg::CLASS_FLUID);
		case (cls) inside
			5'd21, 5'd22, 5'd23: m.xm = ggs_pkg::AX_FWD;
			5'd27, 5'd28, 5'd29: m.xm = ggs_pkg::AX_BWD;
			default:             m.xm = ggs_pkg::AX_CTR;
		endcase
		case (cls) inside
			5'd21, 5'd24, 5'd27: m.ym = ggs_pkg::AX_FWD;
			5'd23, 5'd26, 5'd29: m.ym = ggs_pkg::AX_BWD;
			default:             m.ym = ggs_pkg::AX_CTR;
		endcase
		return m;
	endfunction

	// Weight of the center value in a one-sided difference
	function automatic ggs_pkg::coef_t center_coef(input ggs_pkg::axis_t a);
		ggs_pkg::coef_t c;
		case (a)
			ggs_pkg::AX_FWD: c = ggs_pkg::CF_M3;
			ggs_pkg::AX_BWD: c = ggs_pkg::CF_P3;
			default:         c = ggs_pkg::CF_ZERO;
		endcase
		return c;
	endfunction

	// Multiply a stored value by a small stencil weight
	function automatic logic signed [ggs_pkg::ACC_W-1:0] scale(
		input logic [ggs_pkg::VAL_W-1:0] v,
		input ggs_pkg::coef_t            c
	);
		logic signed [ggs_pkg::ACC_W-1:0] e;
		logic signed [ggs_pkg::ACC_W-1:0] e3;
		logic signed [ggs_pkg::ACC_W-1:0] e4;
		logic signed [ggs_pkg::ACC_W-1:0] r;
		e  = ggs_pkg::ACC_W'($signed(v));
		e3 = e + (e <<< 1);
		e4 = e <<< 2;
		case (c)
			ggs_pkg::CF_P1: r = e;
			ggs_pkg::CF_M1: r = -e;
			ggs_pkg::CF_P3: r = e3;
			ggs_pkg::CF_M3: r = -e3;
			ggs_pkg::CF_P4: r = e4;
			ggs_pkg::CF_M4: r = -e4;
			default:        r = '0;
		endcase
		return r;
	endfunction

	// Apply sign to a rounded magnitude and saturate to 32 bits
	function automatic logic [ggs_pkg::VAL_W-1:0] sat_result(
		input logic                      neg,
		input logic [ggs_pkg::MAG_W-1:0] q
	);
		logic [ggs_pkg::VAL_W-1:0] r;
		if (!neg) begin
			if (q > {{(ggs_pkg::MAG_W-ggs_pkg::VAL_W+1){1'b0}}, {(ggs_pkg::VAL_W-1){1'b1}}})
				r = {1'b0, {(ggs_pkg::VAL_W-1){1'b1}}};
			else
				r = q[ggs_pkg::VAL_W-1:0];
		end else begin
			if (q[ggs_pkg::MAG_W-1:ggs_pkg::VAL_W-1] != '0)
				r = {1'b1, {(ggs_pkg::VAL_W-1){1'b0}}};
			else
				r = -q[ggs_pkg::VAL_W-1:0];
		end
		return r;
	endfunction

	// Configuration registers
	logic [ggs_pkg::CFG_W-1:0] width_q;
	logic [ggs_pkg::CFG_W-1:0] height_q;

	// Captured request
	logic                      is_wr_q;
	logic [ggs_pkg::CRD_W-1:0] x_q;
	logic [ggs_pkg::CRD_W-1:0] y_q;
	logic [ggs_pkg::VAL_W-1:0] val_q;
	logic [ggs_pkg::CLS_W-1:0] cls_q;

	// Node store and read pipeline
	logic [WORD_W-1:0]          store_q [ggs_pkg::STORE_DEPTH];
	logic [WORD_W-1:0]          rdata_q;
	logic                       rd_vld_s1;
	logic                       ctr_s1;
	ggs_pkg::coef_t             cx_s1;
	ggs_pkg::coef_t             cy_s1;

	// Accumulated numerators and decoded class
	ggs_pkg::mode_t                   mode_q;
	logic signed [ggs_pkg::ACC_W-1:0] acc_x_q;
	logic signed [ggs_pkg::ACC_W-1:0] acc_y_q;

	// Result register
	logic                      out_vld_q;
	logic [ggs_pkg::VAL_W-1:0] dx_q;
	logic [ggs_pkg::VAL_W-1:0] dy_q;
	logic                      skip_q;

	logic [ggs_pkg::CFG_W-1:0]  nx;
	logic [ggs_pkg::CFG_W-1:0]  ny;
	logic [ggs_pkg::ADDR_W-1:0] waddr;
	logic [ggs_pkg::ADDR_W-1:0] raddr;
	logic [ggs_pkg::VAL_W-1:0]  rval;
	ggs_pkg::mode_t             rmode;

	logic                       neg_x;
	logic                       neg_y;
	logic [ggs_pkg::ACC_W-1:0]  abs_x;
	logic [ggs_pkg::ACC_W-1:0]  abs_y;
	logic [ggs_pkg::MAG_W-1:0]  mag_x;
	logic [ggs_pkg::MAG_W-1:0]  mag_y;
	logic [ggs_pkg::MAG_W-1:0]  bias_x;
	logic [ggs_pkg::MAG_W-1:0]  bias_y;
	logic [ggs_pkg::MAG_W-1:0]  half_x;
	logic [ggs_pkg::MAG_W-1:0]  half_y;
	logic [ggs_pkg::DIV_W-1:0]  dvd_x;
	logic [ggs_pkg::DIV_W-1:0]  dvd_y;
	logic [ggs_pkg::DIV_W-1:0]  quo_x;
	logic [ggs_pkg::DIV_W-1:0]  quo_y;
	logic                       done_x;
	logic                       done_y;
	logic [ggs_pkg::MAG_W-1:0]  q_x;
	logic [ggs_pkg::MAG_W-1:0]  q_y;

	// Hold grid size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ggs_pkg::CFG_W'(ggs_pkg::MAX_COLS);
			height_q <= ggs_pkg::CFG_W'(ggs_pkg::MAX_ROWS);
		end else if (cfg_we) begin
			case (cfg_addr)
				ggs_pkg::CFG_GRID_WIDTH:  width_q  <= cfg_wdata;
				ggs_pkg::CFG_GRID_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign nx = clamp_size(width_q, ggs_pkg::CFG_W'(ggs_pkg::MAX_COLS));
	assign ny = clamp_size(height_q, ggs_pkg::CFG_W'(ggs_pkg::MAX_ROWS));

	// Capture the request on an input transfer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			is_wr_q <= (in_type == ggs_pkg::REQ_WRITE);
			x_q     <= in_x;
			y_q     <= in_y;
			val_q   <= in_value;
			cls_q   <= in_class;
		end
	end

	// Store addresses, row major
	assign waddr = {y_q, x_q};
	assign raddr = {nbr(cmd.tap.ys, y_q, ny), nbr(cmd.tap.xs, x_q, nx)};

	// Single-port node store with registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_we)
			store_q[waddr] <= {cls_q, val_q};
		if (cmd.rd_en)
			rdata_q <= store_q[raddr];
	end

	// Carry the weights alongside the read
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			ctr_s1 <= cmd.rd_center;
			cx_s1  <= cmd.tap.cx;
			cy_s1  <= cmd.tap.cy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_vld_s1 <= 1'b0;
		else
			rd_vld_s1 <= cmd.rd_en;
	end

	assign rval  = rdata_q[ggs_pkg::VAL_W-1:0];
	assign rmode = class_mode(rdata_q[WORD_W-1 -: ggs_pkg::CLS_W]);

	// Decode class on the center read; accumulate weighted neighbors after it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= '0;
		else if (rd_vld_s1 && ctr_s1)
			mode_q <= rmode;
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (ctr_s1) begin
				acc_x_q <= scale(rval, center_coef(rmode.xm));
				acc_y_q <= scale(rval, center_coef(rmode.ym));
			end else begin
				acc_x_q <= acc_x_q + scale(rval, cx_s1);
				acc_y_q <= acc_y_q + scale(rval, cy_s1);
			end
		end
	end

	// Magnitudes and rounding biases
	always_comb begin
		neg_x  = acc_x_q[ggs_pkg::ACC_W-1];
		neg_y  = acc_y_q[ggs_pkg::ACC_W-1];
		abs_x  = neg_x ? -acc_x_q : acc_x_q;
		abs_y  = neg_y ? -acc_y_q : acc_y_q;
		mag_x  = abs_x[ggs_pkg::MAG_W-1:0];
		mag_y  = abs_y[ggs_pkg::MAG_W-1:0];
		bias_x = mag_x + ggs_pkg::MAG_W'(6);
		bias_y = mag_y + ggs_pkg::MAG_W'(6);
		half_x = (mag_x + ggs_pkg::MAG_W'(1)) >> 1;
		half_y = (mag_y + ggs_pkg::MAG_W'(1)) >> 1;
		dvd_x  = ggs_pkg::DIV_W'(bias_x[ggs_pkg::MAG_W-1:2]);
		dvd_y  = ggs_pkg::DIV_W'(bias_y[ggs_pkg::MAG_W-1:2]);
	end

	// Divide by 12 as a shift by 2 and a division by 3
	ggs_div3 u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd_x),
		.quotient (quo_x),
		.done     (done_x)
	);

	ggs_div3 u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd_y),
		.quotient (quo_y),
		.done     (done_y)
	);

	assign q_x = mode_q.fluid ? ggs_pkg::MAG_W'(quo_x) : half_x;
	assign q_y = mode_q.fluid ? ggs_pkg::MAG_W'(quo_y) : half_y;

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			dx_q   <= sat_result(neg_x, q_x);
			dy_q   <= sat_result(neg_y, q_y);
			skip_q <= 1'b0;
		end else if (cmd.out_skip) begin
			dx_q   <= '0;
			dy_q   <= '0;
			skip_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.out_load || cmd.out_skip)
			out_vld_q <= 1'b1;
		else if (out_ready)
			out_vld_q <= 1'b0;
	end

	assign out_valid = out_vld_q;
	assign deriv_x   = dx_q;
	assign deriv_y   = dy_q;
	assign skipped   = skip_q;

	// Status to the controller
	always_comb begin
		sts.is_wr    = is_wr_q;
		sts.in_grid  = (ggs_pkg::CFG_W'(x_q) < nx) && (ggs_pkg::CFG_W'(y_q) < ny);
		sts.mode     = mode_q;
		sts.div_done = done_x && done_y;
		sts.out_free = !out_vld_q || out_ready;
	end

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && skip_q |-> (dx_q == '0) && (dy_q == '0))
		else $error("skipped result carries a nonzero derivative");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_vld_q && !skip_q)
		else $error("computed result not presented after load");

endmodule

`default_nettype wire

// File: rtl/ggs_ctrl.sv
`default_nettype none

module ggs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ggs_pkg::sts_t sts,
	output ggs_pkg::cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_DECODE  = 4'd1;
	localparam logic [3:0] ST_CENTER  = 4'd2;
	localparam logic [3:0] ST_MODE    = 4'd3;
	localparam logic [3:0] ST_TAPS    = 4'd4;
	localparam logic [3:0] ST_DRAIN   = 4'd5;
	localparam logic [3:0] ST_DIVGO   = 4'd6;
	localparam logic [3:0] ST_DIVWAIT = 4'd7;
	localparam logic [3:0] ST_FIN     = 4'd8;
	localparam logic [3:0] ST_SKIP    = 4'd9;

	// Neighbor read and weights for one step of the sequence
	function automatic ggs_pkg::tap_t tap_for(
		input logic [ggs_pkg::STEP_W-1:0] step,
		input ggs_pkg::mode_t             m
	);
		ggs_pkg::tap_t t;
		t.xs = ggs_pkg::SEL_C;
		t.ys = ggs_pkg::SEL_C;
		t.cx = ggs_pkg::CF_ZERO;
		t.cy = ggs_pkg::CF_ZERO;
		if (m.fluid) begin
			case (step)
				3'd0: begin
					t.xs = ggs_pkg::SEL_P; t.cx = ggs_pkg::CF_P4;
				end
				3'd1: begin
					t.xs = ggs_pkg::SEL_N; t.cx = ggs_pkg::CF_M4;
				end
				3'd2: begin
					t.xs = ggs_pkg::SEL_P; t.ys = ggs_pkg::SEL_P;
					t.cx = ggs_pkg::CF_P1; t.cy = ggs_pkg::CF_P1;
				end
				3'd3: begin
					t.xs = ggs_pkg::SEL_N; t.ys = ggs_pkg::SEL_N;
					t.cx = ggs_pkg::CF_M1; t.cy = ggs_pkg::CF_M1;
				end
				3'd4: begin
					t.xs = ggs_pkg::SEL_P; t.ys = ggs_pkg::SEL_N;
					t.cx = ggs_pkg::CF_P1; t.cy = ggs_pkg::CF_M1;
				end
				3'd5: begin
					t.xs = ggs_pkg::SEL_N; t.ys = ggs_pkg::SEL_P;
					t.cx = ggs_pkg::CF_M1; t.cy = ggs_pkg::CF_P1;
				end
				3'd6: begin
					t.ys = ggs_pkg::SEL_P; t.cy = ggs_pkg::CF_P4;
				end
				default: begin
					t.ys = ggs_pkg::SEL_N; t.cy = ggs_pkg::CF_M4;
				end
			endcase
		end else begin
			case (step)
				3'd0: begin
					case (m.xm)
						ggs_pkg::AX_FWD: begin t.xs = ggs_pkg::SEL_P2; t.cx = ggs_pkg::CF_M1; end
						ggs_pkg::AX_BWD: begin t.xs = ggs_pkg::SEL_N2; t.cx = ggs_pkg::CF_P1; end
						default:         begin t.xs = ggs_pkg::SEL_P;  t.cx = ggs_pkg::CF_P1; end
					endcase
				end
				3'd1: begin
					case (m.xm)
						ggs_pkg::AX_FWD: begin t.xs = ggs_pkg::SEL_P; t.cx = ggs_pkg::CF_P4; end
						ggs_pkg::AX_BWD: begin t.xs = ggs_pkg::SEL_N; t.cx = ggs_pkg::CF_M4; end
						default:         begin t.xs = ggs_pkg::SEL_N; t.cx = ggs_pkg::CF_M1; end
					endcase
				end
				3'd2: begin
					case (m.ym)
						ggs_pkg::AX_FWD: begin t.ys = ggs_pkg::SEL_P2; t.cy = ggs_pkg::CF_M1; end
						ggs_pkg::AX_BWD: begin t.ys = ggs_pkg::SEL_N2; t.cy = ggs_pkg::CF_P1; end
						default:         begin t.ys = ggs_pkg::SEL_P;  t.cy = ggs_pkg::CF_P1; end
					endcase
				end
				default: begin
					case (m.ym)
						ggs_pkg::AX_FWD: begin t.ys = ggs_pkg::SEL_P; t.cy = ggs_pkg::CF_P4; end
						ggs_pkg::AX_BWD: begin t.ys = ggs_pkg::SEL_N; t.cy = ggs_pkg::CF_M4; end
						default:         begin t.ys = ggs_pkg::SEL_N; t.cy = ggs_pkg::CF_M1; end
					endcase
				end
			endcase
		end
		return t;
	endfunction

	logic [3:0]                  state_q;
	logic [3:0]                  state_d;
	logic [ggs_pkg::STEP_W-1:0]  step_q;
	logic [ggs_pkg::STEP_W-1:0]  step_d;
	logic [ggs_pkg::STEP_W-1:0]  last_step;

	assign last_step = sts.mode.fluid ? ggs_pkg::STEP_W'(ggs_pkg::TAPS_FLUID - 1)
	                                  : ggs_pkg::STEP_W'(ggs_pkg::TAPS_EDGE - 1);

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		step_d        = step_q;
		cmd           = '0;
		cmd.tap       = tap_for(step_q, sts.mode);
		in_ready      = (state_q == ST_IDLE);
		cmd.capture   = in_valid && in_ready;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture)
					state_d = ST_DECODE;
			end
			ST_DECODE: begin
				step_d = '0;
				if (sts.is_wr) begin
					cmd.mem_we = 1'b1;
					state_d    = ST_IDLE;
				end else if (!sts.in_grid) begin
					state_d = ST_SKIP;
				end else begin
					cmd.rd_en     = 1'b1;
					cmd.rd_center = 1'b1;
					cmd.tap.xs    = ggs_pkg::SEL_C;
					cmd.tap.ys    = ggs_pkg::SEL_C;
					state_d       = ST_CENTER;
				end
			end
			ST_CENTER: begin
				state_d = ST_MODE;
			end
			ST_MODE: begin
				if (sts.mode.solid) begin
					state_d = ST_SKIP;
				end else begin
					cmd.rd_en = 1'b1;
					step_d    = step_q + ggs_pkg::STEP_W'(1);
					state_d   = ST_TAPS;
				end
			end
			ST_TAPS: begin
				cmd.rd_en = 1'b1;
				if (step_q == last_step)
					state_d = ST_DRAIN;
				else
					step_d = step_q + ggs_pkg::STEP_W'(1);
			end
			ST_DRAIN: begin
				state_d = sts.mode.fluid ? ST_DIVGO : ST_FIN;
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVWAIT;
			end
			ST_DIVWAIT: begin
				if (sts.div_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_SKIP: begin
				if (sts.out_free) begin
					cmd.out_skip = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load || cmd.out_skip) |-> sts.out_free)
		else $error("result loaded over an untaken result");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_we |-> !cmd.rd_en)
		else $error("store read and written in one cycle");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_DECODE))
		else $error("accepted request not decoded");

	a_div_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider reports done right after start");

endmodule

`default_nettype wire

// File: rtl/grid_gradient_stencil_core.sv
// Gradient engine for a scalar field on a node grid of up to 64 x 64.
// Input stream: each transfer is one request. tuser = 0 stores a node value
// and class code at (coord_x, coord_y); tuser = 1 asks for the x and y
// derivatives at that node. Only compute requests produce an output transfer.
// Output stream: deriv_x, deriv_y (Q16.16, saturated) and a skipped flag set
// for solid nodes and for nodes outside the grid in use.
// Config port: index 0 sets columns in use, index 1 rows in use; write only
// while no request is in flight.
// All node reads share the single port of the node store (one center read
// plus 4 or 8 neighbor reads); the fluid case adds a nibble-serial divide
// by 3 of 9 steps. One request is worked at a time.
// Reset: grid size returns to 64 x 64, no result pending. Node storage is
// not cleared; every node must be written before it is read.
// Output stall: a finished result waits in the output register and the next
// request is still accepted; its own result waits until that one is taken.
`default_nettype none

module grid_gradient_stencil_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// coord_x[5:0], coord_y[11:6], node_value[43:12], node_class[48:44], zero pad
	input  wire logic [ggs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// req_type[0]
	input  wire logic                               s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// deriv_x[31:0], deriv_y[63:32]
	output logic      [ggs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// skipped[0]
	output logic                                    m_axis_tuser,
	input  wire logic                               cfg_we,
	input  wire logic [ggs_pkg::CFG_AW-1:0]         cfg_addr,
	input  wire logic [ggs_pkg::CFG_W-1:0]          cfg_wdata
);

	localparam int X_LO = 0;
	localparam int Y_LO = X_LO + ggs_pkg::CRD_W;
	localparam int V_LO = Y_LO + ggs_pkg::CRD_W;
	localparam int C_LO = V_LO + ggs_pkg::VAL_W;

	ggs_pkg::cmd_t             cmd;
	ggs_pkg::sts_t             sts;
	logic [ggs_pkg::VAL_W-1:0] deriv_x;
	logic [ggs_pkg::VAL_W-1:0] deriv_y;

	ggs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ggs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_type   (s_axis_tuser),
		.in_x      (s_axis_tdata[X_LO +: ggs_pkg::CRD_W]),
		.in_y      (s_axis_tdata[Y_LO +: ggs_pkg::CRD_W]),
		.in_value  (s_axis_tdata[V_LO +: ggs_pkg::VAL_W]),
		.in_class  (s_axis_tdata[C_LO +: ggs_pkg::CLS_W]),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.deriv_x   (deriv_x),
		.deriv_y   (deriv_y),
		.skipped   (m_axis_tuser)
	);

	// Pack the result fields
	assign m_axis_tdata = {deriv_y, deriv_x};

endmodule

`default_nettype wire
